[design/vkf_pkg.sv]
// Shared types, constants and fixed-point helpers of the vertical Kalman filter.
package vkf_pkg;

  localparam int unsigned SONAR_WINDOW_DEF = 100;

  localparam logic signed [31:0] GRAVITY_Q      = 32'sd642253;
  localparam logic signed [31:0] BLEND_OLD_Q    = 32'sd19661;
  localparam logic signed [31:0] BLEND_NEW_Q    = 32'sd45875;
  localparam logic signed [31:0] HEIGHT_RESET_Q = 32'sd11665;
  localparam logic signed [31:0] ONE_Q          = 32'sd65536;
  localparam logic [30:0]        NOISE_RESET    = 31'd65536;

  localparam int unsigned DIV_NUM_W = 51;
  localparam int unsigned DIV_DEN_W = 36;

  localparam logic [1:0] FUNC_IMU   = 2'd0;
  localparam logic [1:0] FUNC_BARO  = 2'd1;
  localparam logic [1:0] FUNC_SONAR = 2'd2;

  localparam logic [1:0] CFG_ACCEL = 2'd0;
  localparam logic [1:0] CFG_BARO  = 2'd1;
  localparam logic [1:0] CFG_SONAR = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] sample;
    logic [16:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic signed [31:0] vertical_speed;
    logic signed [31:0] baro_offset;
    logic signed [31:0] height_var;
  } out_item_t;

  typedef struct packed {
    logic                        start;
    logic signed [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0]        den;
  } div_req_t;

  function automatic logic signed [63:0] sx64(input logic signed [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Round half toward plus infinity after a right shift by 16 (or 17), then saturate.
  function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] v,
                                                 input logic by17);
    logic signed [63:0] r;
    if (by17) begin
      r = (v + 64'sd65536) >>> 17;
    end else begin
      r = (v + 64'sd32768) >>> 16;
    end
    return sat32(r);
  endfunction

endpackage

[design/vkf_mul.sv]
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
module vkf_mul import vkf_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

[design/vkf_div.sv]
// Radix-2 restoring divider, signed dividend, positive divisor, saturated 32-bit quotient.
module vkf_div import vkf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_req_t           req_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_q;
  logic                 done_q;
  logic                 neg_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_NUM_W-1:0] n_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;

  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;
  logic [DIV_NUM_W-1:0] mag;
  logic                 last;

  always_comb begin
    trial = {rem_q, n_q[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
    last  = cnt_q == CNT_W'(DIV_NUM_W - 1);
    if (req_i.num[DIV_NUM_W-1]) begin
      mag = ~$unsigned(req_i.num) + 1'b1;
    end else begin
      mag = $unsigned(req_i.num);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        n_q    <= mag;
        rem_q  <= '0;
        den_q  <= req_i.den;
        neg_q  <= req_i.num[DIV_NUM_W-1];
      end else if (busy_q) begin
        // The dividend shifts out at the top while quotient bits shift in at the bottom.
        n_q   <= {n_q[DIV_NUM_W-2:0], fits};
        rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (neg_q) begin
      quo_o = (n_q > DIV_NUM_W'(64'h8000_0000)) ? 32'sh80000000 : -$signed(n_q[31:0]);
    end else begin
      quo_o = (n_q > DIV_NUM_W'(64'h7fff_ffff)) ? 32'sh7fffffff : $signed(n_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule

[design/vertical_kalman_filter.sv]
// Vertical Kalman filter top level: sequencer around one multiplier and one divider.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o  in_item_i  (func, sample, time_step)
//   out      output     out_valid_o/out_stall_i out_item_o (estimates, height_var)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A predict request performs 16 multiplies on the shared multiplier. A barometer request
// runs three 51-step divides for the gains plus 12 multiplies; a sonar request adds one
// more divide for the window mean and two blending multiplies. The input stalls
// for the whole request. A finished result waits in the output register while the
// next request runs. Reset is immediate; no clearing pass is needed.
module vertical_kalman_filter import vkf_pkg::*; #(
  parameter int unsigned SONAR_WINDOW = SONAR_WINDOW_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);

  localparam int unsigned PTR_W = $clog2(SONAR_WINDOW);
  localparam int unsigned CNT_W = $clog2(SONAR_WINDOW + 1);
  localparam int unsigned SUM_W = 32 + $clog2(SONAR_WINDOW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_PRED, ST_SON_START, ST_SON_DIV, ST_BL1, ST_BL2, ST_BL3,
    ST_WIN, ST_CSETUP, ST_CSTART, ST_CDIV, ST_CMUL, ST_DONE
  } state_e;

  state_e             state_q;
  logic [3:0]         step_q;
  logic               phase_q;
  in_item_t           item_q;
  logic signed [31:0] h_q, v_q, b_q;
  logic signed [31:0] p_q [9];
  logic signed [31:0] w0_q, qw0_q, qw1_q, y_q, z_q, mean_q;
  logic signed [63:0] tmp_q;
  logic signed [31:0] k_q [3];
  logic signed [31:0] hp_q [3];
  logic signed [35:0] s_q;
  logic [30:0]        accel_q, baro_q, sonar_q;
  logic signed [SUM_W-1:0] win_sum_q;
  logic [CNT_W-1:0]   win_cnt_q;
  logic [PTR_W-1:0]   win_ptr_q;
  logic signed [31:0] old_q;
  logic signed [31:0] win_mem [SONAR_WINDOW];
  out_item_t          out_q;
  logic               out_valid_q;

  logic signed [31:0] dt, uz, qn, qm;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               wb, win_full;
  logic [30:0]        r_sel;
  logic signed [33:0] ph [3];
  logic signed [33:0] ph_sel;
  logic signed [31:0] hp [3];
  logic signed [35:0] s_c;
  logic [3:0]         pidx;
  logic [1:0]         prow, pcol;
  div_req_t           div_req;
  logic               div_done;
  logic signed [31:0] div_quo;

  vkf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  vkf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    dt = {15'd0, item_q.time_step};
    uz = sat32(sx64(item_q.sample) - sx64(GRAVITY_Q));
    qn = {1'b0, accel_q};
    qm = rnd_sat(prod, 1'b0);
    wb = item_q.func == FUNC_BARO;
    r_sel = wb ? baro_q : sonar_q;
    win_full = win_cnt_q == CNT_W'(SONAR_WINDOW);
    for (int i = 0; i < 3; i++) begin
      ph[i] = {{2{p_q[3*i][31]}}, p_q[3*i]} +
              (wb ? {{2{p_q[3*i+2][31]}}, p_q[3*i+2]} : 34'sd0);
      hp[i] = sat32(sx64(p_q[i]) + (wb ? sx64(p_q[6+i]) : 64'sd0));
    end
    s_c = {{2{ph[0][33]}}, ph[0]} + (wb ? {{2{ph[2][33]}}, ph[2]} : 36'sd0) +
          {5'd0, r_sel};
    case (step_q[1:0])
      2'd0:    ph_sel = ph[0];
      2'd1:    ph_sel = ph[1];
      default: ph_sel = ph[2];
    endcase
  end

  // Covariance update order in the correction: row-major after the three state updates.
  always_comb begin
    pidx = step_q - 4'd3;
    case (pidx)
      4'd0:    begin prow = 2'd0; pcol = 2'd0; end
      4'd1:    begin prow = 2'd0; pcol = 2'd1; end
      4'd2:    begin prow = 2'd0; pcol = 2'd2; end
      4'd3:    begin prow = 2'd1; pcol = 2'd0; end
      4'd4:    begin prow = 2'd1; pcol = 2'd1; end
      4'd5:    begin prow = 2'd1; pcol = 2'd2; end
      4'd6:    begin prow = 2'd2; pcol = 2'd0; end
      4'd7:    begin prow = 2'd2; pcol = 2'd1; end
      default: begin prow = 2'd2; pcol = 2'd2; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PRED: begin
        case (step_q)
          4'd0:    begin mul_a = dt;    mul_b = dt;     end
          4'd1:    begin mul_a = dt;    mul_b = v_q;    end
          4'd2:    begin mul_a = w0_q;  mul_b = uz;     end
          4'd3:    begin mul_a = dt;    mul_b = uz;     end
          4'd4:    begin mul_a = dt;    mul_b = p_q[3]; end
          4'd5:    begin mul_a = dt;    mul_b = p_q[4]; end
          4'd6:    begin mul_a = dt;    mul_b = p_q[5]; end
          4'd7:    begin mul_a = dt;    mul_b = p_q[1]; end
          4'd8:    begin mul_a = dt;    mul_b = p_q[4]; end
          4'd9:    begin mul_a = dt;    mul_b = p_q[7]; end
          4'd10:   begin mul_a = qn;    mul_b = w0_q;   end
          4'd11:   begin mul_a = qn;    mul_b = dt;     end
          4'd12:   begin mul_a = qw0_q; mul_b = w0_q;   end
          4'd13:   begin mul_a = qw0_q; mul_b = dt;     end
          4'd14:   begin mul_a = qw1_q; mul_b = w0_q;   end
          default: begin mul_a = qw1_q; mul_b = dt;     end
        endcase
      end
      ST_BL1: begin
        mul_a = BLEND_OLD_Q;
        mul_b = mean_q;
      end
      ST_BL2: begin
        mul_a = BLEND_NEW_Q;
        mul_b = item_q.sample;
      end
      ST_CMUL: begin
        if (step_q < 4'd3) begin
          mul_a = k_q[step_q[1:0]];
          mul_b = y_q;
        end else begin
          mul_a = k_q[prow];
          mul_b = hp_q[pcol];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state_q)
      ST_SON_START: begin
        div_req.start = win_cnt_q != '0;
        div_req.num   = {{(DIV_NUM_W-SUM_W){win_sum_q[SUM_W-1]}}, win_sum_q};
        div_req.den   = DIV_DEN_W'(win_cnt_q);
      end
      ST_CSTART: begin
        div_req.start = s_q > 36'sd0;
        div_req.num   = {ph_sel[33], ph_sel, 16'd0};
        div_req.den   = $unsigned(s_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    old_q <= win_mem[win_ptr_q];
    if (state_q == ST_WIN) begin
      win_mem[win_ptr_q] <= z_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      h_q         <= HEIGHT_RESET_Q;
      v_q         <= '0;
      b_q         <= '0;
      for (int i = 0; i < 9; i++) begin
        p_q[i] <= ONE_Q;
      end
      win_sum_q   <= '0;
      win_cnt_q   <= '0;
      win_ptr_q   <= '0;
      accel_q     <= NOISE_RESET;
      baro_q      <= NOISE_RESET;
      sonar_q     <= NOISE_RESET;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ACCEL: accel_q <= cfg_data_i;
          CFG_BARO:  baro_q  <= cfg_data_i;
          CFG_SONAR: sonar_q <= cfg_data_i;
          default: ;
        endcase
      end
      // In the finishing state the output register is refilled below instead.
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_item_i;
            state_q <= ST_DISP;
          end
        end
        ST_DISP: begin
          step_q  <= '0;
          phase_q <= 1'b0;
          case (item_q.func)
            FUNC_IMU:   state_q <= ST_PRED;
            FUNC_BARO: begin
              y_q <= sat32(sx64(item_q.sample) - sx64(h_q) - sx64(b_q));
              state_q <= ST_CSETUP;
            end
            FUNC_SONAR: state_q <= ST_SON_START;
            default:    state_q <= ST_DONE;
          endcase
        end
        ST_PRED: begin
          phase_q <= ~phase_q;
          if (phase_q) begin
            case (step_q)
              4'd0:  w0_q  <= rnd_sat(prod, 1'b1);
              4'd1:  tmp_q <= sx64(qm);
              4'd2:  h_q   <= sat32(sx64(h_q) + tmp_q + sx64(qm));
              4'd3:  v_q   <= sat32(sx64(v_q) + sx64(qm));
              4'd4, 4'd7, 4'd12: p_q[0] <= sat32(sx64(p_q[0]) + sx64(qm));
              4'd5, 4'd13:       p_q[1] <= sat32(sx64(p_q[1]) + sx64(qm));
              4'd6:              p_q[2] <= sat32(sx64(p_q[2]) + sx64(qm));
              4'd8, 4'd14:       p_q[3] <= sat32(sx64(p_q[3]) + sx64(qm));
              4'd9:              p_q[6] <= sat32(sx64(p_q[6]) + sx64(qm));
              4'd10: qw0_q <= qm;
              4'd11: qw1_q <= qm;
              default:           p_q[4] <= sat32(sx64(p_q[4]) + sx64(qm));
            endcase
            if (step_q == 4'd15) begin
              state_q <= ST_DONE;
            end else begin
              step_q <= step_q + 4'd1;
            end
          end
        end
        ST_SON_START: begin
          if (win_cnt_q != '0) begin
            state_q <= ST_SON_DIV;
          end else begin
            z_q     <= item_q.sample;
            state_q <= ST_WIN;
          end
        end
        ST_SON_DIV: begin
          if (div_done) begin
            mean_q <= div_quo;
            if (div_quo != '0) begin
              state_q <= ST_BL1;
            end else begin
              z_q     <= item_q.sample;
              state_q <= ST_WIN;
            end
          end
        end
        ST_BL1: state_q <= ST_BL2;
        ST_BL2: begin
          tmp_q   <= prod;
          state_q <= ST_BL3;
        end
        ST_BL3: begin
          z_q     <= rnd_sat(tmp_q + prod, 1'b0);
          state_q <= ST_WIN;
        end
        ST_WIN: begin
          // Once the window is full the oldest entry leaves the running sum.
          if (!win_full) begin
            win_cnt_q <= win_cnt_q + 1'b1;
          end
          win_sum_q <= win_sum_q
                       - (win_full ? {{(SUM_W-32){old_q[31]}}, old_q} : SUM_W'(0))
                       + {{(SUM_W-32){z_q[31]}}, z_q};
          win_ptr_q <= (win_ptr_q == PTR_W'(SONAR_WINDOW - 1)) ? '0 : win_ptr_q + 1'b1;
          y_q       <= sat32(sx64(z_q) - sx64(h_q));
          state_q   <= ST_CSETUP;
        end
        ST_CSETUP: begin
          for (int i = 0; i < 3; i++) begin
            hp_q[i] <= hp[i];
          end
          s_q     <= s_c;
          step_q  <= '0;
          state_q <= ST_CSTART;
        end
        ST_CSTART: begin
          state_q <= (s_q > 36'sd0) ? ST_CDIV : ST_DONE;
        end
        ST_CDIV: begin
          if (div_done) begin
            k_q[step_q[1:0]] <= div_quo;
            if (step_q == 4'd2) begin
              step_q  <= '0;
              phase_q <= 1'b0;
              state_q <= ST_CMUL;
            end else begin
              step_q  <= step_q + 4'd1;
              state_q <= ST_CSTART;
            end
          end
        end
        ST_CMUL: begin
          phase_q <= ~phase_q;
          if (phase_q) begin
            case (step_q)
              4'd0:    h_q <= sat32(sx64(h_q) + sx64(qm));
              4'd1:    v_q <= sat32(sx64(v_q) + sx64(qm));
              4'd2:    b_q <= sat32(sx64(b_q) + sx64(qm));
              default: p_q[pidx] <= sat32(sx64(p_q[pidx]) - sx64(qm));
            endcase
            if (step_q == 4'd11) begin
              state_q <= ST_DONE;
            end else begin
              step_q <= step_q + 4'd1;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.height         <= h_q;
            out_q.vertical_speed <= v_q;
            out_q.baro_offset    <= b_q;
            out_q.height_var     <= p_q[0];
            out_valid_q          <= 1'b1;
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[design/vkf_checker.sv]
// Port-level checks of the vertical Kalman filter and their binding to the top level.
module vkf_checker import vkf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // Once a request is taken the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a request was taken");

  // A new result only appears at the end of a request in progress.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed or dropped");

endmodule

bind vertical_kalman_filter vkf_checker u_vkf_checker (.*);

[tb/sv/vkf_checker.sv]
// Checker for the vertical Kalman filter: predicts each result and compares it.
`timescale 1ns / 1ps
module vkf_scoreboard import vkf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  output int        errors_o,
  output int        pending_o,
  output int        results_o
);

  localparam int WIN = SONAR_WINDOW_DEF;

  logic [30:0] q_accel, q_baro, q_sonar;
  logic signed [31:0] h_est, v_est, b_est;
  logic signed [31:0] cov [3][3];
  logic signed [31:0] win [WIN];
  longint win_sum;
  int win_cnt, win_ptr;
  out_item_t estimates_q [$];

  function automatic logic signed [31:0] clip(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Arithmetic shift rounds toward minus infinity, so adding half first gives half-up.
  function automatic logic signed [31:0] rmul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip((p + 32768) >>> 16);
  endfunction

  task automatic run_predict(input logic signed [31:0] acc, input logic signed [31:0] dt);
    logic signed [31:0] w0, uz, qq, qw0, qw1;
    logic signed [31:0] m [3][3];
    longint p;
    p = longint'(dt) * longint'(dt);
    w0 = clip((p + 65536) >>> 17);
    uz = clip(longint'(acc) - longint'(GRAVITY_Q));
    qq = $signed({1'b0, q_accel});
    h_est = clip(longint'(h_est) + rmul(dt, v_est) + rmul(w0, uz));
    v_est = clip(longint'(v_est) + rmul(dt, uz));
    m = cov;
    for (int j = 0; j < 3; j++) m[0][j] = clip(longint'(cov[0][j]) + rmul(dt, cov[1][j]));
    for (int i = 0; i < 3; i++) m[i][0] = clip(longint'(m[i][0]) + rmul(dt, m[i][1]));
    qw0 = rmul(qq, w0);
    qw1 = rmul(qq, dt);
    m[0][0] = clip(longint'(m[0][0]) + rmul(qw0, w0));
    m[0][1] = clip(longint'(m[0][1]) + rmul(qw0, dt));
    m[1][0] = clip(longint'(m[1][0]) + rmul(qw1, w0));
    m[1][1] = clip(longint'(m[1][1]) + rmul(qw1, dt));
    cov = m;
  endtask

  task automatic run_correct(input logic signed [31:0] y, input logic [30:0] r,
                             input bit with_bias);
    longint ph [3];
    logic signed [31:0] hp [3];
    logic signed [31:0] k [3];
    longint s;
    for (int i = 0; i < 3; i++) begin
      ph[i] = longint'(cov[i][0]) + (with_bias ? longint'(cov[i][2]) : 0);
      hp[i] = clip(longint'(cov[0][i]) + (with_bias ? longint'(cov[2][i]) : 0));
    end
    s = ph[0] + (with_bias ? ph[2] : 0) + longint'({33'd0, r});
    if (s <= 0) return;
    for (int i = 0; i < 3; i++) k[i] = clip((ph[i] * 65536) / s);
    h_est = clip(longint'(h_est) + rmul(k[0], y));
    v_est = clip(longint'(v_est) + rmul(k[1], y));
    b_est = clip(longint'(b_est) + rmul(k[2], y));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cov[i][j] = clip(longint'(cov[i][j]) - rmul(k[i], hp[j]));
  endtask

  function automatic logic signed [31:0] blend_sonar(input logic signed [31:0] rd);
    logic signed [31:0] z;
    longint mean;
    z = rd;
    if (win_cnt != 0) begin
      mean = win_sum / win_cnt;
      if (mean != 0) z = clip((19661 * mean + 45875 * longint'(rd) + 32768) >>> 16);
    end
    if (win_cnt < WIN) win_cnt++;
    else win_sum -= win[win_ptr];
    win[win_ptr] = z;
    win_sum += z;
    win_ptr = (win_ptr + 1) % WIN;
    return z;
  endfunction

  task automatic predict_estimates(input in_item_t it);
    out_item_t e;
    logic signed [31:0] z;
    case (it.func)
      FUNC_IMU: begin
        run_predict(it.sample, $signed({15'd0, it.time_step}));
      end
      FUNC_BARO: begin
        run_correct(clip(longint'(it.sample) - h_est - b_est), q_baro, 1'b1);
      end
      FUNC_SONAR: begin
        z = blend_sonar(it.sample);
        run_correct(clip(longint'(z) - h_est), q_sonar, 1'b0);
      end
      default: ;
    endcase
    e.height = h_est;
    e.vertical_speed = v_est;
    e.baro_offset = b_est;
    e.height_var = cov[0][0];
    estimates_q = {estimates_q, e};
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      q_accel = NOISE_RESET;
      q_baro = NOISE_RESET;
      q_sonar = NOISE_RESET;
      h_est = HEIGHT_RESET_Q;
      v_est = '0;
      b_est = '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) cov[i][j] = ONE_Q;
      win_sum = 0;
      win_cnt = 0;
      win_ptr = 0;
      estimates_q.delete();
      errors_o = 0;
      results_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ACCEL: q_accel = cfg_data_i;
          CFG_BARO:  q_baro = cfg_data_i;
          CFG_SONAR: q_sonar = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (estimates_q.size() == 0) begin
          $error("result with no request outstanding");
          errors_o++;
        end else begin
          e = estimates_q.pop_front();
          compare_field("height", e.height, out_item_i.height);
          compare_field("vertical_speed", e.vertical_speed, out_item_i.vertical_speed);
          compare_field("baro_offset", e.baro_offset, out_item_i.baro_offset);
          compare_field("height_var", e.height_var, out_item_i.height_var);
        end
      end
      if (in_valid_i && !in_stall_i) predict_estimates(in_item_i);
    end
    pending_o = estimates_q.size();
  end

endmodule

[tb/sv/tb_vertical_kalman_filter.sv]
// Testbench top of the vertical Kalman filter: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_vertical_kalman_filter import vkf_pkg::*; ();

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [30:0] cfg_data_i = '0;
  int errors, pending, results;
  bit calm = 0;
  bit hold_off = 0;
  int sent = 0;

  always #6 clk_i = ~clk_i;

  vertical_kalman_filter u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  vkf_scoreboard u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver stalls in random bursts, plus one long hold-off.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (1200) @(negedge clk_i);
        hold_off = 0;
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 6);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_request(input logic [1:0] f, input logic signed [31:0] s,
                              input logic [16:0] dt);
    if (!calm && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    @(negedge clk_i);
    in_item_i <= '{func: f, sample: s, time_step: dt};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random request: mostly plausible flight data, some full-range noise.
  task automatic random_request();
    logic [1:0] f;
    logic signed [31:0] s;
    logic [16:0] dt;
    f = $urandom_range(0, 9) == 0 ? FUNC_UNUSED : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) s = $urandom;
    else if (f == FUNC_IMU) s = $signed($urandom_range(0, 1_300_000)) - 0;
    else s = $signed($urandom_range(0, 800_000)) - 100_000;
    dt = $urandom_range(0, 19) == 0 ? 17'($urandom_range(0, 65536))
                                    : 17'($urandom_range(0, 1400));
    send_request(f, s, dt);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Directed: extremes, every kind, an empty sonar window, and an unused kind.
    send_request(FUNC_SONAR, 32'sd65536, '0);
    send_request(FUNC_SONAR, 32'sd70000, '0);
    send_request(FUNC_IMU, 32'sh7fffffff, 17'd65536);
    send_request(FUNC_IMU, 32'sh80000000, 17'd65536);
    send_request(FUNC_IMU, GRAVITY_Q, 17'h1ffff);
    send_request(FUNC_BARO, 32'sh7fffffff, '0);
    send_request(FUNC_BARO, 32'sh80000000, '0);
    send_request(FUNC_SONAR, 32'sh80000000, '0);
    send_request(FUNC_SONAR, 32'sh7fffffff, '0);
    send_request(FUNC_UNUSED, 32'sh5a5a5a5a, 17'h1ffff);
    send_request(FUNC_IMU, 32'sd0, '0);
    send_request(FUNC_BARO, 32'sd0, 17'h0aaaa);
    send_request(FUNC_SONAR, 32'sd0, 17'h15555);
    write_reg(CFG_ACCEL, '0);
    write_reg(CFG_BARO, '0);
    write_reg(CFG_SONAR, '0);
    write_reg(CFG_UNUSED, 31'h7fffffff);
    for (int i = 0; i < 12; i++) random_request();
    write_reg(CFG_ACCEL, 31'h7fffffff);
    write_reg(CFG_BARO, 31'h7fffffff);
    write_reg(CFG_SONAR, 31'h7fffffff);
    for (int i = 0; i < 300; i++) random_request();
    hold_off = 1;
    for (int i = 0; i < 5; i++) random_request();
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_ACCEL, 31'($urandom_range(0, 300000)));
      write_reg(CFG_BARO, 31'($urandom_range(0, 300000)));
      write_reg(CFG_SONAR, 31'($urandom));
      for (int i = 0; i < 300; i++) random_request();
    end
    write_reg(CFG_ACCEL, NOISE_RESET);
    write_reg(CFG_BARO, NOISE_RESET);
    write_reg(CFG_SONAR, NOISE_RESET);
    calm = 1;
    for (int i = 0; i < 280; i++) random_request();
    for (int i = 0; i < 200000 && pending != 0; i++) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    $display("Sent %0d requests over several noise settings; %0d results checked.",
             sent, results);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/vkf_pkg.sv
design/vkf_mul.sv
design/vkf_div.sv
design/vertical_kalman_filter.sv
design/vkf_checker.sv
tb/sv/vkf_checker.sv
tb/sv/tb_vertical_kalman_filter.sv
